// File: rtl/bll_pkg.sv
package bll_pkg;

  // Number of nodes in the store.
  localparam int CAPACITY = 64;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the stream payloads.
  localparam int VAL_W    = 32;
  localparam int ECOUNT_W = 7;
  localparam int IN_W     = VAL_W;
  localparam int OUT_W    = ((3 * VAL_W + ECOUNT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_REMOVE     = 2'd2,
    REQ_DUMP       = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_LINK,
    S_RM_WALK,
    S_RM_HEAD,
    S_DUMP_WALK,
    S_DONE
  } state_t;

  // One entry of the node store.
  typedef struct packed {
    logic [SLOT_W-1:0] link;
    logic [VAL_W-1:0]  value;
  } node_t;

endpackage

// File: rtl/bounded_linked_list_engine_unit.sv
// A push writes its new node when the request is taken and gives its result from S_DONE; a push
// at the back of a nonempty list that is not full first links the old tail in S_PUSH_LINK. A remove
// walks the list, and a match at the head passes through S_RM_HEAD; a dump gives one beat per cycle if taken.
// Requests are served one at a time, bounded by the single read port of the node store, through
// which the list walk goes one node per cycle, save while a dump beat is stalled at the output.
// Reset (rst, synchronous, active high) empties the list and the occupancy map.
module bounded_linked_list_engine_unit (
  input  logic                      clk,
  input  logic                      rst,
  // Request channel.
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [bll_pkg::IN_W-1:0]  s_tdata,  // [31:0] element_value
  input  logic [1:0]                s_tuser,  // [1:0] req_type
  // Result channel.
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [bll_pkg::OUT_W-1:0] m_tdata,  // [31:0] element_out, [63:32] head_value,
                                              // [95:64] tail_value, [102:96] element_count,
                                              // [103] zero
  output logic [1:0]                m_tuser,  // [1:0] status
  output logic                      m_tlast   // last_of_run
);
  import bll_pkg::*;

  // The node store holds each value together with its next link, so one read returns
  // everything a walk step needs. It has no reset; what is read from a slot not in use never reaches a result.
  node_t mem [CAPACITY];
  node_t rdata;

  state_t state, state_next;

  // List bookkeeping. The head and tail values are mirrored in registers so every
  // result can report them without a store access.
  logic [CAPACITY-1:0] in_use;
  logic [SLOT_W-1:0]   head_slot, tail_slot;
  logic [VAL_W-1:0]    head_val, tail_val;
  logic [CNT_W-1:0]    count;

  // The lowest free slot is searched once per cycle and registered. The map only changes while a request
  // is in progress, and S_DONE lies between each change and the next request, so the slot is current then.
  logic [SLOT_W-1:0]   free_idx, free_slot;

  // Walk and request context.
  logic [SLOT_W-1:0]   cur, prev, new_slot;
  logic [VAL_W-1:0]    prev_val, req_val;
  logic [CNT_W-1:0]    step_n;
  status_t             status_r;

  // Decoded controls.
  req_t                req;
  logic                s_fire, out_free, full, hit, last_step, is_push;
  logic [SLOT_W-1:0]   rd_addr, wr_addr;
  logic                wr_en;
  node_t               wr_node;
  logic                out_load, out_last;
  status_t             out_status;
  logic [VAL_W-1:0]    out_elem, out_head, out_tail;

  assign req       = req_t'(s_tuser);
  assign s_tready  = (state == S_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign full      = (count == CNT_W'(CAPACITY));
  assign is_push   = (req == REQ_PUSH_FRONT) || (req == REQ_PUSH_BACK);
  // During a walk, rdata holds the node at cur.
  assign hit       = (rdata.value == req_val);
  assign last_step = ((step_n + CNT_W'(1)) == count);

  // An empty list reports all ones for head and tail.
  assign out_head  = (count == '0) ? '1 : head_val;
  assign out_tail  = (count == '0) ? '1 : tail_val;

  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_fire) begin
          case (req)
            REQ_PUSH_FRONT: state_next = S_DONE;
            REQ_PUSH_BACK:  state_next = (full || count == '0) ? S_DONE : S_PUSH_LINK;
            REQ_REMOVE:     state_next = (count == '0) ? S_DONE : S_RM_WALK;
            REQ_DUMP:       state_next = (count == '0) ? S_DONE : S_DUMP_WALK;
            default:        state_next = S_DONE;
          endcase
        end
      end
      S_PUSH_LINK: state_next = S_DONE;
      S_RM_WALK: begin
        if (hit) begin
          state_next = (step_n == '0) ? S_RM_HEAD : S_DONE;
        end else if (last_step) begin
          state_next = S_DONE;
        end
      end
      S_RM_HEAD: state_next = S_DONE;
      S_DUMP_WALK: begin
        if (out_free && last_step) begin
          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Store accesses and result loading.
  always_comb begin
    rd_addr    = cur;
    wr_en      = 1'b0;
    wr_addr    = free_slot;
    wr_node    = '{link: '0, value: s_tdata};
    out_load   = 1'b0;
    out_status = status_r;
    out_elem   = '0;
    out_last   = 1'b1;
    case (state)
      S_IDLE: begin
        rd_addr = head_slot;
        if (s_fire && is_push && !full) begin
          // A new front node points at the old head; any other new node ends the list.
          wr_en   = 1'b1;
          wr_addr = free_slot;
          wr_node = '{link: (req == REQ_PUSH_FRONT && count != '0) ? head_slot : '0,
                      value: s_tdata};
        end
      end
      S_PUSH_LINK: begin
        // Hook the new node behind the old tail.
        wr_en   = 1'b1;
        wr_addr = tail_slot;
        wr_node = '{link: new_slot, value: tail_val};
      end
      S_RM_WALK: begin
        // Fetch the following node; on a head match this returns the new head value.
        rd_addr = rdata.link;
        if (hit && step_n != '0) begin
          // Bypass the matched node.
          wr_en   = 1'b1;
          wr_addr = prev;
          wr_node = '{link: rdata.link, value: prev_val};
        end
      end
      S_DUMP_WALK: begin
        // Hold the read on the current node while the output is stalled.
        rd_addr    = out_free ? rdata.link : cur;
        out_load   = out_free;
        out_status = ST_OK;
        out_elem   = rdata.value;
        out_last   = last_step;
      end
      S_DONE: begin
        out_load = out_free;
      end
      default: begin
        rd_addr = cur;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_use    <= '0;
      head_slot <= '0;
      tail_slot <= '0;
      count     <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_fire && is_push && !full) begin
            in_use[free_slot] <= 1'b1;
            count             <= count + CNT_W'(1);
            if (count == '0) begin
              head_slot <= free_slot;
              tail_slot <= free_slot;
            end else if (req == REQ_PUSH_FRONT) begin
              head_slot <= free_slot;
            end
          end
        end
        S_PUSH_LINK: tail_slot <= new_slot;
        S_RM_WALK: begin
          if (hit) begin
            in_use[cur] <= 1'b0;
            count       <= count - CNT_W'(1);
            if (step_n == '0) begin
              head_slot <= rdata.link;
            end else if (cur == tail_slot) begin
              tail_slot <= prev;
            end
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // Datapath registers and the node store.
  always_ff @(posedge clk) begin
    free_slot <= free_idx;
    rdata     <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_node;
    end
    case (state)
      S_IDLE: begin
        if (s_fire) begin
          req_val  <= s_tdata;
          new_slot <= free_slot;
          cur      <= head_slot;
          step_n   <= '0;
          if (is_push) begin
            status_r <= full ? ST_FULL : ST_OK;
            if (!full) begin
              if (count == '0) begin
                head_val <= s_tdata;
                tail_val <= s_tdata;
              end else if (req == REQ_PUSH_FRONT) begin
                head_val <= s_tdata;
              end
            end
          end else begin
            status_r <= ST_EMPTY;
          end
        end
      end
      S_PUSH_LINK: tail_val <= req_val;
      S_RM_WALK: begin
        if (hit) begin
          status_r <= ST_OK;
          if (step_n != '0 && cur == tail_slot) begin
            tail_val <= prev_val;
          end
        end else begin
          status_r <= ST_NOT_FOUND;
          prev     <= cur;
          prev_val <= rdata.value;
          cur      <= rdata.link;
          step_n   <= step_n + CNT_W'(1);
        end
      end
      S_RM_HEAD: head_val <= rdata.value;
      S_DUMP_WALK: begin
        if (out_free) begin
          cur    <= rdata.link;
          step_n <= step_n + CNT_W'(1);
        end
      end
      default: begin
        cur <= cur;
      end
    endcase
    if (out_load) begin
      m_tuser <= out_status;
      m_tlast <= out_last;
      m_tdata <= {{(OUT_W - 3 * VAL_W - ECOUNT_W){1'b0}}, ECOUNT_W'(count),
                  out_tail, out_head, out_elem};
    end
  end

endmodule

// File: rtl/bll_checker.sv
module bll_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [bll_pkg::OUT_W-1:0] m_tdata,
  input logic [1:0]                m_tuser,
  input logic                      m_tlast
);
  import bll_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // Requests are served one at a time.
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in progress");

  // A beat with an error status is the last of its run; only a dump gives several beats, all of them ok.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tlast)
    else $error("error status on a beat that is not last");

  // An empty list reports all ones for head and tail.
  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[102:96] == '0 |->
      m_tdata[63:32] == '1 && m_tdata[95:64] == '1)
    else $error("empty list reports a head or tail value");

endmodule

bind bounded_linked_list_engine_unit bll_checker u_bll_checker (.*);
